/* sv/lbg_pkg.sv */
// Package for the Legendre basis generator: field widths, register indexes
// and saturation helpers. No dependencies.
`default_nettype none

package lbg_pkg;

    localparam int S_W       = 18;
    localparam int G_W       = 24;
    localparam int D_W       = 32;
    localparam int IDX_W     = 4;
    localparam int CNT_W     = 5;
    localparam int DIM_W     = 2;
    localparam int CFG_IDX_W = 1;
    localparam int NUM_COMP  = 3;

    localparam int T_W      = 20;
    localparam int U_W      = 48;
    localparam int OP1_W    = 33;
    localparam int ACC_W    = 64;
    localparam int HI_SHIFT = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_ORDER_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIMENSIONS  = 1'b1;

    localparam logic [DIM_W-1:0] DIM_TWO   = 2'd2;
    localparam logic [DIM_W-1:0] DIM_RESET = 2'd3;
    localparam logic [1:0]       LAST_COMP = 2'd2;

    localparam int VAL_MAX = 131071;
    localparam int VAL_MIN = -131072;

    localparam logic signed [ACC_W-1:0] VAL_MAX_A = 64'sd131071;
    localparam logic signed [ACC_W-1:0] VAL_MIN_A = -64'sd131072;
    localparam logic signed [ACC_W-1:0] DER_MAX_A = 64'sd2147483647;
    localparam logic signed [ACC_W-1:0] DER_MIN_A = -64'sd2147483648;

    function automatic logic signed [S_W-1:0] sat_val(input logic signed [ACC_W-1:0] v);
        logic signed [S_W-1:0] r;
        if (v > VAL_MAX_A)
            r = S_W'(VAL_MAX);
        else if (v < VAL_MIN_A)
            r = S_W'(VAL_MIN);
        else
            r = S_W'(v);
        return r;
    endfunction

    function automatic logic signed [D_W-1:0] sat_der(input logic signed [ACC_W-1:0] v);
        logic signed [D_W-1:0] r;
        if (v > DER_MAX_A)
            r = D_W'(DER_MAX_A);
        else if (v < DER_MIN_A)
            r = D_W'(DER_MIN_A);
        else
            r = D_W'(v);
        return r;
    endfunction

endpackage

`default_nettype wire

/* sv/legendre_basis_with_gradient.sv */
// Legendre basis with gradient: Bonnet recurrence on one shared multiplier
// and accumulator under a step sequencer. Depends on lbg_pkg.
// Order 0 is emitted in the cycle after the request, order 1 in the cycle after that; every higher
// order runs 18 multiply-accumulate passes (multiply, then accumulate), 8 write-backs and 1 result.
// Busy from the request until the last result; stays idle for n = 0; no result stall.
// Reset returns to idle with order_count 0 and dimensions 3.
`default_nettype none

module legendre_basis_with_gradient #(
    parameter int MAX_ORDER = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lbg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lbg_pkg::CNT_W-1:0]           cfg_data,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [lbg_pkg::S_W-1:0]      coord_s,
    input  logic signed [lbg_pkg::G_W-1:0]      grad_s_x,
    input  logic signed [lbg_pkg::G_W-1:0]      grad_s_y,
    input  logic signed [lbg_pkg::G_W-1:0]      grad_s_z,
    output logic                                result_valid,
    output logic [lbg_pkg::IDX_W-1:0]           order_index,
    output logic signed [lbg_pkg::S_W-1:0]      basis_value,
    output logic signed [lbg_pkg::D_W-1:0]      deriv_x,
    output logic signed [lbg_pkg::D_W-1:0]      deriv_y,
    output logic signed [lbg_pkg::D_W-1:0]      deriv_z,
    output logic                                last_of_run
);

    import lbg_pkg::*;

    localparam int LW     = $clog2(MAX_ORDER);
    localparam int NW     = $clog2(MAX_ORDER + 1);
    localparam int CW     = FRAC_BITS + 1;
    localparam int OP2_W  = (FRAC_BITS + 2 > S_W) ? FRAC_BITS + 2 : S_W;
    localparam int PROD_W = OP1_W + OP2_W;

    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(longint'(1) << (FRAC_BITS - 1));
    localparam logic signed [S_W-1:0]   P_ONE =
        S_W'((FRAC_BITS >= S_W - 1) ? VAL_MAX : (1 << FRAC_BITS));

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_WB,
        ST_EMIT
    } state_t;

    typedef enum logic [2:0] {
        SP_AS,
        SP_TP,
        SP_BP,
        SP_SD,
        SP_GP,
        SP_AL,
        SP_AH,
        SP_BD
    } step_t;

    logic [CNT_W-1:0] order_count_reg;
    logic [DIM_W-1:0] dimensions_reg;

    state_t state_reg;
    step_t  step_reg;
    step_t  step_succ;
    logic [1:0]    comp_reg;
    logic [LW-1:0] l_reg;
    logic [NW-1:0] n_reg;
    logic          last_reg;
    logic          two_d_reg;

    logic signed [S_W-1:0]    s_reg;
    logic signed [G_W-1:0]    g_reg [NUM_COMP];
    logic signed [T_W-1:0]    t_reg;
    logic signed [U_W-1:0]    u_reg;
    logic signed [S_W-1:0]    p1_reg;
    logic signed [S_W-1:0]    p2_reg;
    logic signed [D_W-1:0]    d1_reg [NUM_COMP];
    logic signed [D_W-1:0]    d2_reg [NUM_COMP];
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [S_W-1:0]    basis_value_reg;
    logic signed [D_W-1:0]    deriv_reg [NUM_COMP];

    logic [CW-1:0] coef_a_tab [MAX_ORDER];
    logic [CW-1:0] coef_b_tab [MAX_ORDER];

    logic [CW-1:0]            a_coef;
    logic [CW-1:0]            b_coef;
    logic signed [OP1_W-1:0]  op1;
    logic signed [OP2_W-1:0]  op2;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [ACC_W-1:0]  term;
    logic signed [ACC_W-1:0]  base;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  rs;
    logic                     is_start;
    logic                     is_end;
    logic                     is_neg;
    logic                     two_d;
    logic [NW-1:0]            n_eff;

    // Recurrence coefficients (2l-1)/l and (l-1)/l, rounded to nearest
    for (genvar i = 0; i < MAX_ORDER; i++) begin : g_coef
        if (i < 2) begin : g_low
            assign coef_a_tab[i] = '0;
            assign coef_b_tab[i] = '0;
        end else begin : g_rec
            localparam longint CA = ((longint'(2 * i - 1) << FRAC_BITS) + i / 2) / i;
            localparam longint CB = ((longint'(i - 1) << FRAC_BITS) + i / 2) / i;
            assign coef_a_tab[i] = CW'(CA);
            assign coef_b_tab[i] = CW'(CB);
        end
    end

    assign two_d = (dimensions_reg == DIM_TWO);
    assign n_eff = (int'(order_count_reg) > MAX_ORDER) ? NW'(MAX_ORDER) : NW'(order_count_reg);

    always_comb
    begin
        a_coef    = coef_a_tab[l_reg];
        b_coef    = coef_b_tab[l_reg];
        op1       = '0;
        op2       = '0;
        is_start  = 1'b0;
        is_end    = 1'b0;
        is_neg    = 1'b0;
        step_succ = step_t'(step_reg + 3'd1);
        unique case (step_reg)
            SP_AS:
            begin
                op1      = OP1_W'(s_reg);
                op2      = OP2_W'({1'b0, a_coef});
                is_start = 1'b1;
                is_end   = 1'b1;
            end
            SP_TP:
            begin
                op1      = OP1_W'(t_reg);
                op2      = OP2_W'(p1_reg);
                is_start = 1'b1;
            end
            SP_BP:
            begin
                op1    = OP1_W'(p2_reg);
                op2    = OP2_W'({1'b0, b_coef});
                is_end = 1'b1;
                is_neg = 1'b1;
            end
            SP_SD:
            begin
                op1      = OP1_W'(d1_reg[comp_reg]);
                op2      = OP2_W'(s_reg);
                is_start = 1'b1;
            end
            SP_GP:
            begin
                op1    = OP1_W'(g_reg[comp_reg]);
                op2    = OP2_W'(p1_reg);
                is_end = 1'b1;
            end
            SP_AL:
            begin
                op1      = OP1_W'({1'b0, u_reg[HI_SHIFT-1:0]});
                op2      = OP2_W'({1'b0, a_coef});
                is_start = 1'b1;
            end
            SP_AH:
            begin
                op1 = OP1_W'($signed(u_reg[U_W-1:HI_SHIFT]));
                op2 = OP2_W'({1'b0, a_coef});
            end
            SP_BD:
            begin
                op1       = OP1_W'(d2_reg[comp_reg]);
                op2       = OP2_W'({1'b0, b_coef});
                is_end    = 1'b1;
                is_neg    = 1'b1;
                step_succ = SP_SD;
            end
        endcase

        prod_next = op1 * op2;
        term      = ACC_W'(prod_reg);
        if (step_reg == SP_AH)
            term = term <<< HI_SHIFT;
        base      = is_start ? HALF : acc_reg;
        acc_next  = is_neg ? base - term : base + term;
        rs        = acc_reg >>> FRAC_BITS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_count_reg <= '0;
            dimensions_reg  <= DIM_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ORDER_COUNT: order_count_reg <= cfg_data;
                CFG_DIMENSIONS:  dimensions_reg  <= cfg_data[DIM_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            step_reg        <= SP_AS;
            comp_reg        <= '0;
            l_reg           <= '0;
            n_reg           <= '0;
            last_reg        <= 1'b0;
            two_d_reg       <= 1'b0;
            s_reg           <= '0;
            t_reg           <= '0;
            u_reg           <= '0;
            p1_reg          <= '0;
            p2_reg          <= '0;
            prod_reg        <= '0;
            acc_reg         <= '0;
            basis_value_reg <= '0;
            for (int k = 0; k < NUM_COMP; k++)
            begin
                g_reg[k]     <= '0;
                d1_reg[k]    <= '0;
                d2_reg[k]    <= '0;
                deriv_reg[k] <= '0;
            end
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start && n_eff != '0)
                    begin
                        s_reg           <= coord_s;
                        g_reg[0]        <= grad_s_x;
                        g_reg[1]        <= grad_s_y;
                        g_reg[2]        <= two_d ? '0 : grad_s_z;
                        two_d_reg       <= two_d;
                        n_reg           <= n_eff;
                        l_reg           <= '0;
                        basis_value_reg <= P_ONE;
                        for (int k = 0; k < NUM_COMP; k++)
                            deriv_reg[k] <= '0;
                        last_reg        <= (n_eff == NW'(1));
                        state_reg       <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    // advance the recurrence history
                    p2_reg <= p1_reg;
                    p1_reg <= basis_value_reg;
                    for (int k = 0; k < NUM_COMP; k++)
                    begin
                        d2_reg[k] <= d1_reg[k];
                        d1_reg[k] <= deriv_reg[k];
                    end
                    if (last_reg)
                        state_reg <= ST_IDLE;
                    else
                    begin
                        l_reg <= l_reg + LW'(1);
                        if (l_reg == '0)
                        begin
                            basis_value_reg <= s_reg;
                            for (int k = 0; k < NUM_COMP; k++)
                                deriv_reg[k] <= D_W'(g_reg[k]);
                            last_reg <= (n_reg == NW'(2));
                        end
                        else
                        begin
                            step_reg  <= SP_AS;
                            comp_reg  <= '0;
                            state_reg <= ST_MUL;
                        end
                    end
                end
                ST_MUL:
                begin
                    prod_reg  <= prod_next;
                    state_reg <= ST_ACC;
                end
                ST_ACC:
                begin
                    acc_reg <= acc_next;
                    if (is_end)
                        state_reg <= ST_WB;
                    else
                    begin
                        step_reg  <= step_succ;
                        state_reg <= ST_MUL;
                    end
                end
                ST_WB:
                begin
                    step_reg <= step_succ;
                    unique case (step_reg)
                        SP_AS:
                        begin
                            t_reg     <= T_W'(rs);
                            state_reg <= ST_MUL;
                        end
                        SP_BP:
                        begin
                            basis_value_reg <= sat_val(rs);
                            state_reg       <= ST_MUL;
                        end
                        SP_GP:
                        begin
                            u_reg     <= U_W'(rs);
                            state_reg <= ST_MUL;
                        end
                        SP_BD:
                        begin
                            deriv_reg[comp_reg] <= sat_der(rs);
                            if (comp_reg == LAST_COMP)
                            begin
                                last_reg  <= ((NW'(l_reg) + NW'(1)) == n_reg);
                                state_reg <= ST_EMIT;
                            end
                            else
                            begin
                                comp_reg  <= comp_reg + 2'd1;
                                state_reg <= ST_MUL;
                            end
                        end
                        default: state_reg <= ST_IDLE;
                    endcase
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign cfg_ready    = 1'b1;
    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = (state_reg == ST_EMIT);
    assign order_index  = IDX_W'(l_reg);
    assign basis_value  = basis_value_reg;
    assign deriv_x      = deriv_reg[0];
    assign deriv_y      = deriv_reg[1];
    assign deriv_z      = deriv_reg[2];
    assign last_of_run  = last_reg;

    a_first_result: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && order_count_reg != '0 |=> result_valid && order_index == '0)
        else $error("request with nonzero count did not produce order 0 next cycle");

    a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last_of_run |=> !result_valid && !busy)
        else $error("result after the last of a run");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        busy && !result_valid |=> busy)
        else $error("run dropped before its last result");

    a_two_d_z: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && two_d_reg |-> deriv_z == '0)
        else $error("nonzero z gradient in two-dimension mode");

endmodule

`default_nettype wire

/* sim/lbg_checker.sv */
`timescale 1ns / 100ps
// Checker for the Legendre basis generator: tracks register writes, predicts the
// basis run of every accepted request and compares each result strobe against it.
// Depends on lbg_pkg for port widths and register indexes.

module lbg_checker #(
    parameter int MAX_ORDER = 16,
    parameter int FRAC      = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [lbg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lbg_pkg::CNT_W-1:0]           cfg_data,
    input  logic                                start,
    input  logic                                busy,
    input  logic signed [lbg_pkg::S_W-1:0]      coord_s,
    input  logic signed [lbg_pkg::G_W-1:0]      grad_s_x,
    input  logic signed [lbg_pkg::G_W-1:0]      grad_s_y,
    input  logic signed [lbg_pkg::G_W-1:0]      grad_s_z,
    input  logic                                result_valid,
    input  logic [lbg_pkg::IDX_W-1:0]           order_index,
    input  logic signed [lbg_pkg::S_W-1:0]      basis_value,
    input  logic signed [lbg_pkg::D_W-1:0]      deriv_x,
    input  logic signed [lbg_pkg::D_W-1:0]      deriv_y,
    input  logic signed [lbg_pkg::D_W-1:0]      deriv_z,
    input  logic                                last_of_run,
    output int                                  mismatch_cnt,
    output int                                  basis_pending,
    output int                                  basis_checked
);

    import lbg_pkg::*;

    typedef struct {
        logic [IDX_W-1:0]      lvl;
        logic signed [S_W-1:0] value;
        logic signed [D_W-1:0] dx;
        logic signed [D_W-1:0] dy;
        logic signed [D_W-1:0] dz;
        logic                  last;
    } basis_res_t;

    basis_res_t       basis_due_q[$];
    logic [CNT_W-1:0] order_count_reg;
    logic [DIM_W-1:0] dims_reg;

    function automatic longint round_frac(longint v);
        return (v + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint bonnet_a(int l);
        return ((longint'(2 * l - 1) <<< FRAC) + l / 2) / l;
    endfunction

    function automatic longint bonnet_b(int l);
        return ((longint'(l - 1) <<< FRAC) + l / 2) / l;
    endfunction

    function automatic void predict_basis_run(logic signed [S_W-1:0] s_in,
                                              logic signed [G_W-1:0] gx,
                                              logic signed [G_W-1:0] gy,
                                              logic signed [G_W-1:0] gz);
        longint     s, p, p1, p2, a, b, t, u;
        longint     g[3], d[3], d1[3], d2[3];
        int         n;
        bit         two_d;
        basis_res_t r;
        two_d = (dims_reg == DIM_TWO);
        n = (order_count_reg > MAX_ORDER) ? MAX_ORDER : int'(order_count_reg);
        s = s_in;
        g[0] = gx;
        g[1] = gy;
        g[2] = two_d ? 0 : gz;
        p1 = 0;
        p2 = 0;
        for (int k = 0; k < 3; k++)
        begin
            d1[k] = 0;
            d2[k] = 0;
        end
        for (int l = 0; l < n; l++)
        begin
            if (l == 0)
            begin
                p = clamp(longint'(1) <<< FRAC, VAL_MIN, VAL_MAX);
                for (int k = 0; k < 3; k++)
                    d[k] = 0;
            end
            else if (l == 1)
            begin
                p = s;
                for (int k = 0; k < 3; k++)
                    d[k] = g[k];
            end
            else
            begin
                a = bonnet_a(l);
                b = bonnet_b(l);
                t = round_frac(a * s);
                p = clamp(round_frac(t * p1 - b * p2), VAL_MIN, VAL_MAX);
                for (int k = 0; k < 3; k++)
                begin
                    u = round_frac(s * d1[k] + g[k] * p1);
                    d[k] = clamp(round_frac(a * u - b * d2[k]), DER_MIN_A, DER_MAX_A);
                end
            end
            if (two_d)
                d[2] = 0;
            r.lvl   = IDX_W'(l);
            r.value = S_W'(p);
            r.dx    = D_W'(d[0]);
            r.dy    = D_W'(d[1]);
            r.dz    = D_W'(d[2]);
            r.last  = (l == n - 1);
            basis_due_q.push_back(r);
            p2 = p1;
            p1 = p;
            for (int k = 0; k < 3; k++)
            begin
                d2[k] = d1[k];
                d1[k] = d[k];
            end
        end
    endfunction

    function automatic void check_field(string fname, int lvl, longint want, longint got);
        if (want != got)
        begin
            mismatch_cnt++;
            $display("%0t ns: %s mismatch at order %0d: expected %0d, got %0d",
                     $time, fname, lvl, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        basis_res_t want;
        if (!rst_n)
        begin
            order_count_reg = '0;
            dims_reg        = DIM_RESET;
            basis_due_q.delete();
            mismatch_cnt    = 0;
            basis_checked   = 0;
        end
        else
        begin
            if (start && !busy)
                predict_basis_run(coord_s, grad_s_x, grad_s_y, grad_s_z);
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_ORDER_COUNT)
                    order_count_reg = cfg_data;
                else if (cfg_index == CFG_DIMENSIONS)
                    dims_reg = cfg_data[DIM_W-1:0];
            end
            if (result_valid)
            begin
                if (basis_due_q.size() == 0)
                begin
                    mismatch_cnt++;
                    $display("%0t ns: result at order %0d with no request pending",
                             $time, order_index);
                end
                else
                begin
                    want = basis_due_q.pop_front();
                    basis_checked++;
                    check_field("order_index", want.lvl, want.lvl, order_index);
                    check_field("basis_value", want.lvl, want.value, basis_value);
                    check_field("deriv_x", want.lvl, want.dx, deriv_x);
                    check_field("deriv_y", want.lvl, want.dy, deriv_y);
                    check_field("deriv_z", want.lvl, want.dz, deriv_z);
                    check_field("last_of_run", want.lvl, want.last, last_of_run);
                end
            end
        end
        basis_pending = basis_due_q.size();
    end

endmodule

/* sim/tb_legendre_basis_with_gradient.sv */
`timescale 1ns / 100ps
// Testbench top for the Legendre basis generator: clock, reset, register writes,
// directed and random requests, watchdog and verdict.
// Depends on lbg_pkg, legendre_basis_with_gradient and lbg_checker.

module tb_legendre_basis_with_gradient;

    import lbg_pkg::*;

    localparam int               NUM_REQ     = 480;
    localparam int               CALM_TAIL   = 60;
    localparam int               DRAIN       = 64;
    localparam int               STALL_LIMIT = 2000;
    localparam logic [DIM_W-1:0] DIM_THREE   = 2'd3;
    localparam logic [DIM_W-1:0] DIM_ODD0    = 2'd0;
    localparam logic [DIM_W-1:0] DIM_ODD1    = 2'd1;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CNT_W-1:0]       cfg_data;
    logic                   start;
    logic                   busy;
    logic signed [S_W-1:0]  coord_s;
    logic signed [G_W-1:0]  grad_s_x;
    logic signed [G_W-1:0]  grad_s_y;
    logic signed [G_W-1:0]  grad_s_z;
    logic                   result_valid;
    logic [IDX_W-1:0]       order_index;
    logic signed [S_W-1:0]  basis_value;
    logic signed [D_W-1:0]  deriv_x;
    logic signed [D_W-1:0]  deriv_y;
    logic signed [D_W-1:0]  deriv_z;
    logic                   last_of_run;

    int mismatch_cnt;
    int basis_pending;
    int basis_checked;
    int req_sent;
    int settings_run;
    int stall_cycles;

    legendre_basis_with_gradient i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .start        (start),
        .busy         (busy),
        .coord_s      (coord_s),
        .grad_s_x     (grad_s_x),
        .grad_s_y     (grad_s_y),
        .grad_s_z     (grad_s_z),
        .result_valid (result_valid),
        .order_index  (order_index),
        .basis_value  (basis_value),
        .deriv_x      (deriv_x),
        .deriv_y      (deriv_y),
        .deriv_z      (deriv_z),
        .last_of_run  (last_of_run)
    );

    lbg_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .start         (start),
        .busy          (busy),
        .coord_s       (coord_s),
        .grad_s_x      (grad_s_x),
        .grad_s_y      (grad_s_y),
        .grad_s_z      (grad_s_z),
        .result_valid  (result_valid),
        .order_index   (order_index),
        .basis_value   (basis_value),
        .deriv_x       (deriv_x),
        .deriv_y       (deriv_y),
        .deriv_z       (deriv_z),
        .last_of_run   (last_of_run),
        .mismatch_cnt  (mismatch_cnt),
        .basis_pending (basis_pending),
        .basis_checked (basis_checked)
    );

    initial
        clk = 1'b0;

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no activity for %0d cycles", stall_cycles);
            $display("simulation failed");
            $finish;
        end
    end

    // drop start and hold until all expected results are in and the block is idle
    task automatic wait_idle();
        do
        begin
            @(negedge clk);
            start = 1'b0;
        end
        while (basis_pending != 0 || busy);
        repeat (DRAIN) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_config(logic [CNT_W-1:0] count, logic [DIM_W-1:0] dims);
        logic [CNT_W-1:0] dim_word;
        dim_word = {3'($urandom), dims};
        wait_idle();
        write_reg(CFG_ORDER_COUNT, count);
        write_reg(CFG_DIMENSIONS, dim_word);
        settings_run++;
    endtask

    task automatic send_req(logic signed [S_W-1:0] s, logic signed [G_W-1:0] gx,
                            logic signed [G_W-1:0] gy, logic signed [G_W-1:0] gz);
        @(negedge clk);
        start    = 1'b1;
        coord_s  = s;
        grad_s_x = gx;
        grad_s_y = gy;
        grad_s_z = gz;
        do
            @(posedge clk);
        while (busy);
        req_sent++;
    endtask

    function automatic logic signed [G_W-1:0] rand_grad();
        if ($urandom_range(0, 3) == 0)
            return G_W'($urandom);
        return G_W'(int'($urandom_range(0, 131072)) - 65536);
    endfunction

    task automatic send_random_req(bit allow_gap);
        logic signed [S_W-1:0] s;
        int                    pick;
        pick = $urandom_range(0, 15);
        if (pick == 0)
            s = S_W'($urandom);
        else if (pick == 1)
            s = 18'sd65536;
        else if (pick == 2)
            s = -18'sd65536;
        else
            s = S_W'(int'($urandom_range(0, 131072)) - 65536);
        send_req(s, rand_grad(), rand_grad(), rand_grad());
        if (allow_gap && $urandom_range(0, 2) == 0)
        begin
            @(negedge clk);
            start = 1'b0;
            repeat ($urandom_range(0, 14)) @(negedge clk);
        end
    endtask

    initial
    begin
        logic [CNT_W-1:0] count;
        logic [DIM_W-1:0] dims;
        int               batch;
        bit               gappy;
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        start        = 1'b0;
        coord_s      = '0;
        grad_s_x     = '0;
        grad_s_y     = '0;
        grad_s_z     = '0;
        req_sent     = 0;
        settings_run = 0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        set_config(5'd16, DIM_THREE);
        send_req(18'sd65536, 24'sd65536, -24'sd65536, 24'sd0);
        send_req(-18'sd65536, 24'sd65536, 24'sd32768, -24'sd65536);
        send_req(18'sd0, 24'sd65536, 24'sd65536, 24'sd65536);
        send_req(18'sd32768, 24'sd1, -24'sd1, 24'sd1000);
        send_req(18'sd131071, 24'sd8388607, 24'sd8388607, 24'sd8388607);
        send_req(-18'sd131072, -24'sd8388608, -24'sd8388608, -24'sd8388608);
        send_req(-18'sd1, 24'sd8388607, -24'sd8388608, 24'sd0);
        set_config(5'd16, DIM_TWO);
        send_req(18'sd45000, 24'sd70000, -24'sd70000, 24'sd8388607);
        send_req(-18'sd65536, -24'sd8388608, 24'sd8388607, -24'sd8388608);
        set_config(5'd0, DIM_THREE);
        send_req(18'sd12345, 24'sd100, 24'sd200, 24'sd300);
        send_req(-18'sd131072, 24'sd1, 24'sd1, 24'sd1);
        set_config(5'd1, DIM_TWO);
        send_req(-18'sd20000, 24'sd65536, 24'sd5, -24'sd777);
        send_req(18'sd131071, -24'sd8388608, 24'sd8388607, 24'sd8388607);
        set_config(5'd2, DIM_THREE);
        send_req(18'sd65536, 24'sd8388607, -24'sd8388608, 24'sd4096);
        send_req(-18'sd131072, 24'sd8388607, 24'sd8388607, -24'sd8388608);
        set_config(5'd31, DIM_ODD1);
        send_req(18'sd50000, 24'sd65536, -24'sd30000, 24'sd20000);
        send_req(-18'sd131072, 24'sd8388607, 24'sd8388607, 24'sd8388607);
        set_config(5'd17, DIM_ODD0);
        send_req(-18'sd40000, -24'sd65536, 24'sd12000, 24'sd65536);
        send_req(18'sd131071, 24'sd3, -24'sd3, 24'sd8388607);

        while (req_sent < NUM_REQ)
        begin
            case ($urandom_range(0, 9))
                0:       count = 5'd0;
                1:       count = 5'd1;
                2:       count = CNT_W'($urandom_range(17, 31));
                3, 4, 5: count = CNT_W'($urandom_range(2, 8));
                default: count = CNT_W'($urandom_range(9, 16));
            endcase
            case ($urandom_range(0, 9))
                0:       dims = DIM_ODD0;
                1:       dims = DIM_ODD1;
                2, 3, 4: dims = DIM_THREE;
                default: dims = DIM_TWO;
            endcase
            set_config(count, dims);
            batch = $urandom_range(15, 40);
            gappy = ($urandom_range(0, 2) != 0);
            repeat (batch)
                send_random_req(gappy && (req_sent < NUM_REQ - CALM_TAIL));
        end

        wait_idle();
        repeat (100) @(negedge clk);

        $display("%0d requests over %0d register settings, %0d results compared",
                 req_sent, settings_run, basis_checked);
        if (mismatch_cnt == 0 && basis_pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
